FILE: rtl/reif_pkg.sv
// ----------------------------------------------------------------------------
// reif_pkg: shared types and constants
// Widths, register indexes and the side-sample word of the edge fill block.
// ----------------------------------------------------------------------------
`default_nettype none

package reif_pkg;

  localparam int unsigned ValW     = 8;
  localparam int unsigned PosW     = 12;
  localparam int unsigned CfgW     = 13;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned NumSides = 4;
  localparam int unsigned MaxDim   = 4096;

  // weight 65536/d needs 17 bits (d = 1 gives 65536)
  localparam int unsigned WeightW  = 17;
  localparam int unsigned ProdW    = ValW + WeightW;
  localparam int unsigned SumW     = ProdW + 2;
  localparam int unsigned WsumW    = WeightW + 2;
  localparam logic [WeightW-1:0] WeightOne = 17'h10000;

  // sides, in lane order
  localparam int unsigned SideLeft   = 0;
  localparam int unsigned SideTop    = 1;
  localparam int unsigned SideRight  = 2;
  localparam int unsigned SideBottom = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRectW     = 3'd0,
    CfgRectH     = 3'd1,
    CfgHasLeft   = 3'd2,
    CfgHasTop    = 3'd3,
    CfgHasRight  = 3'd4,
    CfgHasBottom = 3'd5
  } cfg_idx_e;

  // border samples and presence of each side
  typedef struct packed {
    logic [NumSides-1:0]           has;
    logic [NumSides-1:0][ValW-1:0] val;
  } reif_side_t;

endpackage

`default_nettype wire

FILE: rtl/reif_fifo.sv
// ----------------------------------------------------------------------------
// reif_fifo: small register queue
// First-in first-out buffer with full and empty flags; depth a power of two.
// ----------------------------------------------------------------------------
`default_nettype none

module reif_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         wr_i,
  input  wire logic [W-1:0] wdata_i,
  output logic              full_o,
  input  wire logic         rd_i,
  output logic [W-1:0]      rdata_o,
  output logic              empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem_q [DEPTH];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // storage words, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) wptr_q <= wptr_q + 1'b1;
      if (do_rd) rptr_q <= rptr_q + 1'b1;
      if (do_wr && !do_rd)      cnt_q <= cnt_q + 1'b1;
      else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/reif_div.sv
// ----------------------------------------------------------------------------
// reif_div: pipelined restoring divider
// One quotient bit per stage over several lanes, with a side word carried along.
// ----------------------------------------------------------------------------
`default_nettype none

module reif_div #(
  parameter int unsigned LANES = 1,
  parameter int unsigned NW    = 8,
  parameter int unsigned DW    = 8,
  parameter int unsigned PW    = 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic [LANES-1:0][DW-1:0]     rem_i,
  input  wire logic [LANES-1:0][NW-1:0]     num_i,
  input  wire logic [LANES-1:0][DW-1:0]     den_i,
  input  wire logic [PW-1:0]                pay_i,
  output logic                              valid_o,
  output logic [LANES-1:0][NW-1:0]          quo_o,
  output logic [PW-1:0]                     pay_o
);

  logic [LANES-1:0][DW-1:0] rem_q [NW];
  logic [LANES-1:0][NW-1:0] num_q [NW];
  logic [LANES-1:0][NW-1:0] quo_q [NW];
  logic [LANES-1:0][DW-1:0] den_q [NW];
  logic [PW-1:0]            pay_q [NW];
  logic [NW-1:0]            vld_q;

  logic [LANES-1:0][DW-1:0] rem_d [NW];
  logic [LANES-1:0][NW-1:0] num_d [NW];
  logic [LANES-1:0][NW-1:0] quo_d [NW];
  logic [LANES-1:0][DW-1:0] den_s [NW];

  // one trial subtraction per stage and lane
  always_comb begin
    logic [DW:0]    trial;
    logic [DW-1:0]  rem_s;
    logic [NW-1:0]  num_s;
    logic [NW-1:0]  quo_s;
    logic           ge;
    for (int k = 0; k < NW; k++) begin
      for (int l = 0; l < LANES; l++) begin
        if (k == 0) begin
          rem_s       = rem_i[l];
          num_s       = num_i[l];
          quo_s       = '0;
          den_s[k][l] = den_i[l];
        end else begin
          rem_s       = rem_q[k-1][l];
          num_s       = num_q[k-1][l];
          quo_s       = quo_q[k-1][l];
          den_s[k][l] = den_q[k-1][l];
        end
        trial = {rem_s, num_s[NW-1]};
        ge    = (trial >= {1'b0, den_s[k][l]});
        rem_d[k][l] = ge ? DW'(trial - {1'b0, den_s[k][l]}) : trial[DW-1:0];
        num_d[k][l] = {num_s[NW-2:0], 1'b0};
        quo_d[k][l] = {quo_s[NW-2:0], ge};
      end
    end
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NW; k++) begin
        rem_q[k] <= rem_d[k];
        num_q[k] <= num_d[k];
        quo_q[k] <= quo_d[k];
        den_q[k] <= den_s[k];
        pay_q[k] <= (k == 0) ? pay_i : pay_q[k-1];
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NW-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[NW-1];
  assign quo_o   = quo_q[NW-1];
  assign pay_o   = pay_q[NW-1];

endmodule

`default_nettype wire

FILE: rtl/reif_front.sv
// ----------------------------------------------------------------------------
// reif_front: register file and distance stage
// Holds the rectangle setup and turns a pixel position into four distances.
// ----------------------------------------------------------------------------
`default_nettype none

module reif_front #(
  parameter int unsigned MAX_DIM = reif_pkg::MaxDim,
  parameter int unsigned DW      = 13
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [reif_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [reif_pkg::CfgW-1:0]         cfg_wdata_i,
  input  wire logic [reif_pkg::PosW-1:0]         pos_x_i,
  input  wire logic [reif_pkg::PosW-1:0]         pos_y_i,
  input  wire logic [reif_pkg::ValW-1:0]         left_val_i,
  input  wire logic [reif_pkg::ValW-1:0]         top_val_i,
  input  wire logic [reif_pkg::ValW-1:0]         right_val_i,
  input  wire logic [reif_pkg::ValW-1:0]         bottom_val_i,
  output logic [reif_pkg::NumSides-1:0][DW-1:0]  dist_o,
  output reif_pkg::reif_side_t                   side_o
);

  localparam logic [DW-1:0] MaxDimL = DW'(MAX_DIM);

  logic [reif_pkg::CfgW-1:0] rect_w_q, rect_h_q;
  logic has_left_q, has_top_q, has_right_q, has_bottom_q;
  logic [DW-1:0] size_w, size_h, px, py;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rect_w_q     <= reif_pkg::CfgW'(1);
      rect_h_q     <= reif_pkg::CfgW'(1);
      has_left_q   <= 1'b0;
      has_top_q    <= 1'b0;
      has_right_q  <= 1'b0;
      has_bottom_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        reif_pkg::CfgRectW:     rect_w_q     <= cfg_wdata_i;
        reif_pkg::CfgRectH:     rect_h_q     <= cfg_wdata_i;
        reif_pkg::CfgHasLeft:   has_left_q   <= cfg_wdata_i[0];
        reif_pkg::CfgHasTop:    has_top_q    <= cfg_wdata_i[0];
        reif_pkg::CfgHasRight:  has_right_q  <= cfg_wdata_i[0];
        reif_pkg::CfgHasBottom: has_bottom_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // clamp size, then distances; far side never below 1
  always_comb begin
    px     = DW'(pos_x_i);
    py     = DW'(pos_y_i);
    size_w = (DW'(rect_w_q) > MaxDimL) ? MaxDimL : DW'(rect_w_q);
    size_h = (DW'(rect_h_q) > MaxDimL) ? MaxDimL : DW'(rect_h_q);
    dist_o[reif_pkg::SideLeft]   = px + 1'b1;
    dist_o[reif_pkg::SideTop]    = py + 1'b1;
    dist_o[reif_pkg::SideRight]  = (size_w > px) ? size_w - px : DW'(1);
    dist_o[reif_pkg::SideBottom] = (size_h > py) ? size_h - py : DW'(1);
  end

  always_comb begin
    side_o.has[reif_pkg::SideLeft]   = has_left_q;
    side_o.has[reif_pkg::SideTop]    = has_top_q;
    side_o.has[reif_pkg::SideRight]  = has_right_q;
    side_o.has[reif_pkg::SideBottom] = has_bottom_q;
    side_o.val[reif_pkg::SideLeft]   = left_val_i;
    side_o.val[reif_pkg::SideTop]    = top_val_i;
    side_o.val[reif_pkg::SideRight]  = right_val_i;
    side_o.val[reif_pkg::SideBottom] = bottom_val_i;
  end

endmodule

`default_nettype wire

FILE: rtl/reif_back.sv
// ----------------------------------------------------------------------------
// reif_back: weighting and normalising pipeline
// Weights by reciprocal distance, sums, and divides by the total weight.
// ----------------------------------------------------------------------------
`default_nettype none

module reif_back #(
  parameter int unsigned DW = 13
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              valid_i,
  input  wire logic [reif_pkg::NumSides-1:0][DW-1:0] dist_i,
  input  wire reif_pkg::reif_side_t              side_i,
  output logic                                   valid_o,
  output logic [reif_pkg::ValW-1:0]              pixel_o
);

  localparam int unsigned NS = reif_pkg::NumSides;
  localparam int unsigned WW = reif_pkg::WeightW;
  localparam int unsigned SW = reif_pkg::SumW;
  localparam int unsigned QW = reif_pkg::WsumW;
  localparam int unsigned VW = reif_pkg::ValW;

  logic [NS-1:0][DW-1:0] zero_rem;
  logic [NS-1:0][WW-1:0] one_num;
  logic [NS-1:0][WW-1:0] wgt;
  logic                  wdiv_vld;
  reif_pkg::reif_side_t  wdiv_side;

  logic                              mul_vld_q, sum_vld_q, rnd_vld_q;
  logic [NS-1:0][reif_pkg::ProdW-1:0] prod_q;
  logic [NS-1:0][WW-1:0]             wm_q;
  logic [SW-1:0]                     sum_q, rnd_q;
  logic [QW-1:0]                     wsum_q, rwsum_q;

  logic [QW-1:0]         fin_rem;
  logic [VW-1:0]         fin_num;
  logic [VW-1:0]         fin_quo;
  logic                  fin_zero;

  always_comb begin
    for (int l = 0; l < NS; l++) begin
      zero_rem[l] = '0;
      one_num[l]  = reif_pkg::WeightOne;
    end
  end

  // weight = 65536 / distance, all four sides side by side
  reif_div #(
    .LANES(NS), .NW(WW), .DW(DW), .PW($bits(reif_pkg::reif_side_t))
  ) u_wdiv (
    .clk_i, .rst_ni, .en_i,
    .valid_i (valid_i),
    .rem_i   (zero_rem),
    .num_i   (one_num),
    .den_i   (dist_i),
    .pay_i   (side_i),
    .valid_o (wdiv_vld),
    .quo_o   (wgt),
    .pay_o   (wdiv_side)
  );

  // products, absent sides masked to zero weight
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < NS; l++) begin
        wm_q[l]   <= wdiv_side.has[l] ? wgt[l] : '0;
        prod_q[l] <= wdiv_side.has[l] ? wdiv_side.val[l] * wgt[l] : '0;
      end
      sum_q   <= SW'(prod_q[0]) + SW'(prod_q[1]) + SW'(prod_q[2]) + SW'(prod_q[3]);
      wsum_q  <= QW'(wm_q[0]) + QW'(wm_q[1]) + QW'(wm_q[2]) + QW'(wm_q[3]);
      rnd_q   <= sum_q + SW'(wsum_q >> 1);
      rwsum_q <= wsum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      sum_vld_q <= 1'b0;
      rnd_vld_q <= 1'b0;
    end else if (en_i) begin
      mul_vld_q <= wdiv_vld;
      sum_vld_q <= mul_vld_q;
      rnd_vld_q <= sum_vld_q;
    end
  end

  // quotient fits in 8 bits, so the upper part is the starting remainder
  assign fin_rem = QW'(rnd_q[SW-1:VW]);
  assign fin_num = rnd_q[VW-1:0];

  reif_div #(
    .LANES(1), .NW(VW), .DW(QW), .PW(1)
  ) u_ndiv (
    .clk_i, .rst_ni, .en_i,
    .valid_i (rnd_vld_q),
    .rem_i   (fin_rem),
    .num_i   (fin_num),
    .den_i   (rwsum_q),
    .pay_i   (rwsum_q == '0),
    .valid_o (valid_o),
    .quo_o   (fin_quo),
    .pay_o   (fin_zero)
  );

  assign pixel_o = fin_zero ? '0 : fin_quo;

endmodule

`default_nettype wire

FILE: rtl/rect_edge_interpolation_fill.sv
// Path: an accepted push enters the distance queue, then 17 weight-divider stages,
// 3 sum stages, 8 divider stages and a write into the result queue.
// Throughput: one word per cycle unless stalled; bit-per-stage dividers fully pipelined.
// The back pipeline stalls as one when a finished word meets a full result queue.
// Reset: asynchronous, active low; registers return to width/height 1, no sides,
// and both queues empty.
// ----------------------------------------------------------------------------
// rect_edge_interpolation_fill: top level
// Front stage and distance queue feeding the weighting pipeline and result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rect_edge_interpolation_fill #(
  parameter int unsigned MAX_DIM = reif_pkg::MaxDim
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [reif_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [reif_pkg::CfgW-1:0]     cfg_wdata_i,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [reif_pkg::PosW-1:0]     pos_x_i,
  input  wire logic [reif_pkg::PosW-1:0]     pos_y_i,
  input  wire logic [reif_pkg::ValW-1:0]     left_val_i,
  input  wire logic [reif_pkg::ValW-1:0]     top_val_i,
  input  wire logic [reif_pkg::ValW-1:0]     right_val_i,
  input  wire logic [reif_pkg::ValW-1:0]     bottom_val_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [reif_pkg::ValW-1:0]          pixel_out_o
);

  localparam int unsigned DimW = $clog2(MAX_DIM + 1);
  localparam int unsigned DW   = (DimW > reif_pkg::CfgW) ? DimW : reif_pkg::CfgW;
  localparam int unsigned NS   = reif_pkg::NumSides;
  localparam int unsigned SdW  = $bits(reif_pkg::reif_side_t);
  localparam int unsigned QW   = NS * DW + SdW;

  logic [NS-1:0][DW-1:0] f_dist, b_dist;
  reif_pkg::reif_side_t  f_side, b_side;
  logic                  mid_empty, mid_rd, out_full, back_vld, back_en;
  logic [reif_pkg::ValW-1:0] back_pixel;

  reif_front #(.MAX_DIM(MAX_DIM), .DW(DW)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .pos_x_i, .pos_y_i, .left_val_i, .top_val_i, .right_val_i, .bottom_val_i,
    .dist_o (f_dist),
    .side_o (f_side)
  );

  // decoupling queue between front and back
  reif_fifo #(.W(QW), .DEPTH(4)) u_mid (
    .clk_i, .rst_ni,
    .wr_i    (push),
    .wdata_i ({f_dist, f_side}),
    .full_o  (full),
    .rd_i    (mid_rd),
    .rdata_o ({b_dist, b_side}),
    .empty_o (mid_empty)
  );

  // back advances unless a finished word cannot leave
  assign back_en = !(back_vld && out_full);
  assign mid_rd  = back_en && !mid_empty;

  reif_back #(.DW(DW)) u_back (
    .clk_i, .rst_ni,
    .en_i    (back_en),
    .valid_i (mid_rd),
    .dist_i  (b_dist),
    .side_i  (b_side),
    .valid_o (back_vld),
    .pixel_o (back_pixel)
  );

  reif_fifo #(.W(reif_pkg::ValW), .DEPTH(2)) u_out (
    .clk_i, .rst_ni,
    .wr_i    (back_vld),
    .wdata_i (back_pixel),
    .full_o  (out_full),
    .rd_i    (pop),
    .rdata_o (pixel_out_o),
    .empty_o (empty)
  );

endmodule

`default_nettype wire

FILE: rtl/reif_checker.sv
// ----------------------------------------------------------------------------
// reif_checker: port-level assertions
// Tracks words in flight and checks the result side over time.
// ----------------------------------------------------------------------------
`default_nettype none

module reif_checker (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     push,
  input wire logic                     full,
  input wire logic                     pop,
  input wire logic                     empty,
  input wire logic [reif_pkg::ValW-1:0] pixel_out_o
);

  localparam int unsigned MaxInFlight = 64;

  logic [7:0] cnt_q;
  logic       acc_in, acc_out;

  assign acc_in  = push && !full;
  assign acc_out = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + {7'd0, acc_in} - {7'd0, acc_out};
    end
  end

  // no result without an accepted word behind it
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> empty)
    else $error("result shown with nothing in flight");

  // words in flight never exceed MaxInFlight (64)
  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 8'(MaxInFlight))
    else $error("too many words in flight");

  // a waiting result stays until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result dropped without pop");

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> $stable(pixel_out_o))
    else $error("result changed while stalled");

endmodule

bind rect_edge_interpolation_fill reif_checker u_reif_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .push        (push),
  .full        (full),
  .pop         (pop),
  .empty       (empty),
  .pixel_out_o (pixel_out_o)
);

`default_nettype wire
